// File: rtl/pwg_pkg.sv
// pwg_pkg: shared types, widths and the quarter-wave sine table function for the
// periodic waveform generator; no dependencies
package pwg_pkg;

   typedef enum logic [1:0] {
      WAVE_SINE,
      WAVE_TRIANGLE,
      WAVE_SQUARE,
      WAVE_SAWTOOTH
   } wave_type;

   typedef enum logic [1:0] {
      CSR_WAVEFORM_SELECT,
      CSR_PHASE_STEP,
      CSR_PHASE_OFFSET,
      CSR_AMPLITUDE
   } csr_index_type;

   localparam int TICK_W      = 32;
   localparam int PHASE_REG_W = 32;
   localparam int AMP_W       = 15;
   localparam int SAMPLE_W    = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int ROM_W       = 31;
   localparam int SINE_FRAC   = 30;
   // wide enough for any saturation bound of the sample width range
   localparam int SAT_W       = 25;

   localparam longint unsigned Q30_ONE     = 64'd1073741824;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // control bits that travel down the pipeline with each transaction
   typedef struct packed {
      logic valid;
      logic neg;
      logic sq_pos;
   } ctl_type;

   // sin(pi/2 * k / 2^tbits) in unsigned Q30, odd series up to x^13, Horner form
   function automatic logic [ROM_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned tbits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sub;
      longint unsigned s;
      x    = (HALF_PI_Q30 * 64'(k)) >> tbits;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sub  = ((x2 * term) >> 30) / 64'd156;
      term = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      sub  = ((x2 * term) >> 30) / 64'd110;
      term = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      sub  = ((x2 * term) >> 30) / 64'd72;
      term = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      sub  = ((x2 * term) >> 30) / 64'd42;
      term = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      sub  = ((x2 * term) >> 30) / 64'd20;
      term = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      sub  = ((x2 * term) >> 30) / 64'd6;
      term = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      s    = (x * term) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      return s[ROM_W-1:0];
   endfunction

endpackage

// File: rtl/pwg_sine_rom.sv
// pwg_sine_rom: quarter-wave sine table with registered read
// depends on pwg_pkg (quarter_sine, ROM_W)
module pwg_sine_rom #(
   parameter int TABLE_BITS = 10
) (
   input  logic                        clock,
   input  logic [TABLE_BITS:0]         rd_addr,
   output logic [pwg_pkg::ROM_W-1:0]   rd_data
);

   localparam int DEPTH = (1 << TABLE_BITS) + 1;

   logic [pwg_pkg::ROM_W-1:0] rom_table [DEPTH];
   logic [pwg_pkg::ROM_W-1:0] rd_data_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_entry
      assign rom_table[g] = pwg_pkg::quarter_sine(g, TABLE_BITS);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom_table[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/pwg_phase.sv
// pwg_phase: phase accumulation stages (tick times step, add offset) and
// per-waveform phase decoding; depends on pwg_pkg
module pwg_phase #(
   parameter int PHASE_BITS = 32,
   parameter int TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [pwg_pkg::TICK_W-1:0]          tick,
   input  logic [pwg_pkg::PHASE_REG_W-1:0]     phase_step,
   input  logic [pwg_pkg::PHASE_REG_W-1:0]     phase_offset,
   input  pwg_pkg::wave_type                   wave_select,
   output pwg_pkg::ctl_type                    out_ctl,
   output logic [TABLE_BITS:0]                 out_addr,
   output logic signed [PHASE_BITS+1:0]        out_operand
);

   localparam int PB = PHASE_BITS;
   localparam int PRW = pwg_pkg::PHASE_REG_W;
   localparam logic [PB-1:0]   HALF          = {1'b1, (PB-1)'(0)};
   localparam logic [PB-1:0]   THREE_QUARTER = {2'b11, (PB-2)'(0)};
   localparam logic [PB+1:0]   FULL_X4W      = (PB+2)'(1) << PB;
   localparam logic [TABLE_BITS:0] TABLE_N   = (TABLE_BITS+1)'(1) << TABLE_BITS;

   // stage 1: phase step multiply
   logic                 valid1_ff;
   logic [PRW-1:0]       prod1_in;
   logic [PRW-1:0]       prod1_ff;

   assign prod1_in = tick * phase_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff <= prod1_in;
   end

   // stage 2: offset add and phase decode
   logic [PRW-1:0]          p32;
   logic [PB+PRW-1:0]       p_ext;
   logic [PB-1:0]           p;
   logic [1:0]              quad;
   logic [TABLE_BITS-1:0]   idx;
   logic [PB-1:0]           q;
   logic [PB-1:0]           d;
   logic [PB+1:0]           tri_t;
   logic [PB+1:0]           saw_2s;
   pwg_pkg::ctl_type        ctl2_in;
   pwg_pkg::ctl_type        ctl2_ff;
   logic [TABLE_BITS:0]     addr2_in;
   logic [TABLE_BITS:0]     addr2_ff;
   logic [PB+1:0]           operand2_in;
   logic [PB+1:0]           operand2_ff;

   always_comb begin
      p32    = prod1_ff + phase_offset;
      // top-align the 32-bit phase into PHASE_BITS bits
      p_ext  = {p32, PB'(0)};
      p      = p_ext[PB+PRW-1 -: PB];
      quad   = p[PB-1 -: 2];
      idx    = p[PB-3 -: TABLE_BITS];
      addr2_in = quad[0] ? (TABLE_N - {1'b0, idx}) : {1'b0, idx};
      q      = p + THREE_QUARTER;
      d      = (q >= HALF) ? (q - HALF) : (HALF - q);
      tri_t  = {d, 2'b00} - FULL_X4W;
      saw_2s = {p[PB-1], p, 1'b0};
      operand2_in    = (wave_select == pwg_pkg::WAVE_TRIANGLE) ? tri_t : saw_2s;
      ctl2_in.valid  = valid1_ff;
      ctl2_in.neg    = quad[1];
      ctl2_in.sq_pos = !p[PB-1] && (|p);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
      end else begin
         ctl2_ff <= ctl2_in;
      end
   end

   always_ff @(posedge clock) begin
      addr2_ff    <= addr2_in;
      operand2_ff <= operand2_in;
   end

   assign out_ctl     = ctl2_ff;
   assign out_addr    = addr2_ff;
   assign out_operand = signed'(operand2_ff);

endmodule

// File: rtl/pwg_scale.sv
// pwg_scale: amplitude scaling, rounding, waveform select and saturation stages
// depends on pwg_pkg
module pwg_scale #(
   parameter int PHASE_BITS  = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pwg_pkg::ctl_type                  in_ctl,
   input  logic signed [PHASE_BITS+1:0]      in_operand,
   input  logic [pwg_pkg::ROM_W-1:0]         rom_data,
   input  pwg_pkg::wave_type                 wave_select,
   input  logic [pwg_pkg::AMP_W-1:0]         amplitude,
   output logic                              out_valid,
   output logic [pwg_pkg::SAMPLE_W-1:0]      out_sample
);

   localparam int PB  = PHASE_BITS;
   localparam int OPW = (PB + 2 > pwg_pkg::ROM_W + 1) ? PB + 2 : pwg_pkg::ROM_W + 1;
   localparam int PW  = OPW + pwg_pkg::AMP_W + 1;
   localparam int SW  = pwg_pkg::SAT_W;
   localparam logic signed [PW-1:0] ROUND_SINE = PW'(1) << (pwg_pkg::SINE_FRAC - 1);
   localparam logic signed [PW-1:0] ROUND_TURN = PW'(1) << (PB - 1);
   localparam logic signed [SW-1:0] SAT_HI     = SW'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SW-1:0] SAT_LO     = -SAT_HI - SW'(1);

   // stage 3: align with the table read
   pwg_pkg::ctl_type            ctl3_ff;
   logic signed [PB+1:0]        operand3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      operand3_ff <= in_operand;
   end

   // stage 4: one shared multiplier for sine entry or triangle/sawtooth operand
   logic signed [OPW-1:0]              mult_op;
   logic signed [pwg_pkg::AMP_W:0]     amp_s;
   logic signed [PW-1:0]               prod4_in;
   logic signed [PW-1:0]               prod4_ff;
   pwg_pkg::ctl_type                   ctl4_ff;

   always_comb begin
      amp_s = signed'({1'b0, amplitude});
      if (wave_select == pwg_pkg::WAVE_SINE) begin
         mult_op = signed'(OPW'({1'b0, rom_data}));
      end else begin
         mult_op = OPW'(operand3_ff);
      end
      prod4_in = PW'(mult_op) * PW'(amp_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else begin
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod4_ff <= prod4_in;
   end

   // stage 5: round, sign, select and saturate
   logic signed [PW-1:0]        sine_sum;
   logic signed [PW-1:0]        turn_sum;
   logic signed [SW-1:0]        sine_mag;
   logic signed [SW-1:0]        turn_val;
   logic signed [SW-1:0]        amp_ext;
   logic signed [SW-1:0]        v;
   logic signed [SW-1:0]        sat;
   logic                        valid5_ff;
   logic [pwg_pkg::SAMPLE_W-1:0] sample5_in;
   logic [pwg_pkg::SAMPLE_W-1:0] sample5_ff;

   always_comb begin
      sine_sum = prod4_ff + ROUND_SINE;
      turn_sum = prod4_ff + ROUND_TURN;
      sine_mag = SW'(sine_sum >>> pwg_pkg::SINE_FRAC);
      turn_val = SW'(turn_sum >>> PB);
      amp_ext  = signed'(SW'({1'b0, amplitude}));
      unique case (wave_select)
         pwg_pkg::WAVE_SINE:     v = ctl4_ff.neg ? -sine_mag : sine_mag;
         pwg_pkg::WAVE_TRIANGLE: v = turn_val;
         pwg_pkg::WAVE_SQUARE:   v = ctl4_ff.sq_pos ? amp_ext : -amp_ext;
         pwg_pkg::WAVE_SAWTOOTH: v = turn_val;
         default:                v = '0;
      endcase
      if (v > SAT_HI) begin
         sat = SAT_HI;
      end else if (v < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = v;
      end
      sample5_in = sat[pwg_pkg::SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= ctl4_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      sample5_ff <= sample5_in;
   end

   assign out_valid  = valid5_ff;
   assign out_sample = sample5_ff;

endmodule

// File: rtl/periodic_waveform_generator.sv
// periodic_waveform_generator: top level, control registers, pipeline wiring
// depends on pwg_pkg, pwg_phase, pwg_sine_rom, pwg_scale

// Direct digital synthesis function generator. Every transaction presents a
// time tick on req_time_tick with start; the sample of the selected waveform
// (sine, triangle, square, sawtooth) at that tick appears on rsp_sample with
// rsp_valid at the end of the pipeline, high for a single cycle only, since
// the receiver has no way to hold it off. The block takes one transaction
// per clock for as long as start stays high; busy is high only during reset.
// The pipeline stages are: phase step multiply, offset add and phase decode,
// sine table read, the amplitude multiplier (shared by sine, triangle and
// sawtooth) and rounding with saturation into the output register. The sine
// table holds 2^TABLE_BITS + 1 entries and needs no load after reset. Control
// registers are written through the csr_ port and take effect for transactions
// started after the write; change them only while no transaction is in flight.
module periodic_waveform_generator #(
   parameter int PHASE_BITS  = 32,
   parameter int TABLE_BITS  = 10,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [pwg_pkg::TICK_W-1:0]          req_time_tick,
   output logic                                rsp_valid,
   output logic [pwg_pkg::SAMPLE_W-1:0]        rsp_sample,
   input  logic                                csr_write_enable,
   input  logic [pwg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pwg_pkg::CSR_DATA_W-1:0]      csr_data
);

   pwg_pkg::wave_type                  wave_select_ff;
   logic [pwg_pkg::PHASE_REG_W-1:0]    phase_step_ff;
   logic [pwg_pkg::PHASE_REG_W-1:0]    phase_offset_ff;
   logic [pwg_pkg::AMP_W-1:0]          amplitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_select_ff  <= pwg_pkg::WAVE_SINE;
         phase_step_ff   <= '0;
         phase_offset_ff <= '0;
         amplitude_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (pwg_pkg::csr_index_type'(csr_index))
            pwg_pkg::CSR_WAVEFORM_SELECT:
               wave_select_ff <= pwg_pkg::wave_type'(csr_data[1:0]);
            pwg_pkg::CSR_PHASE_STEP:
               phase_step_ff <= csr_data[pwg_pkg::PHASE_REG_W-1:0];
            pwg_pkg::CSR_PHASE_OFFSET:
               phase_offset_ff <= csr_data[pwg_pkg::PHASE_REG_W-1:0];
            pwg_pkg::CSR_AMPLITUDE:
               amplitude_ff <= csr_data[pwg_pkg::AMP_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   logic                               accept;
   pwg_pkg::ctl_type                   ph_ctl;
   logic [TABLE_BITS:0]                ph_addr;
   logic signed [PHASE_BITS+1:0]       ph_operand;
   logic [pwg_pkg::ROM_W-1:0]          rom_data;

   assign accept = start && !busy;

   pwg_phase #(
      .PHASE_BITS (PHASE_BITS),
      .TABLE_BITS (TABLE_BITS)
   ) u_phase (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .tick         (req_time_tick),
      .phase_step   (phase_step_ff),
      .phase_offset (phase_offset_ff),
      .wave_select  (wave_select_ff),
      .out_ctl      (ph_ctl),
      .out_addr     (ph_addr),
      .out_operand  (ph_operand)
   );

   pwg_sine_rom #(
      .TABLE_BITS (TABLE_BITS)
   ) u_sine_rom (
      .clock   (clock),
      .rd_addr (ph_addr),
      .rd_data (rom_data)
   );

   pwg_scale #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_ctl      (ph_ctl),
      .in_operand  (ph_operand),
      .rom_data    (rom_data),
      .wave_select (wave_select_ff),
      .amplitude   (amplitude_ff),
      .out_valid   (rsp_valid),
      .out_sample  (rsp_sample)
   );

   // every accepted transaction yields a sample strobe at the end of the pipeline
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted transaction produced no sample");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("sample strobe without a matching transaction");

   a_phase_valid_chain: assert property (@(posedge clock) disable iff (reset)
      ph_ctl.valid |-> $past(accept, 2))
      else $error("phase stage valid out of step with accepted transactions");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for periodic_waveform_generator
// drives time ticks and register writes, predicts every sample and checks rsp_sample
// depends on pwg_pkg and the rtl of periodic_waveform_generator
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pwg_pkg::*;

   localparam int unsigned RUN_LIMIT = 200_000;
   localparam int PIPE_DRAIN = 8;
   localparam int RANDOM_PHASES = 30;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned HALF_PI_FIXED = 64'd1686629713;
   localparam longint TURN = 64'sd4294967296;
   localparam longint HALF_TURN = 64'sd2147483648;
   localparam longint SAMPLE_MAX = 64'sd32767;
   localparam longint SAMPLE_MIN = -64'sd32768;

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [TICK_W-1:0] req_time_tick = '0;
   logic rsp_valid;
   logic [SAMPLE_W-1:0] rsp_sample;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register copies used by the sample predictor
   wave_type cfg_wave = WAVE_SINE;
   logic [31:0] cfg_step = '0;
   logic [31:0] cfg_offset = '0;
   logic [AMP_W-1:0] cfg_amp = '0;

   longint unsigned quarter_wave [0:1024];
   logic [TICK_W-1:0] pending_ticks [$];
   logic [SAMPLE_W-1:0] expected_samples [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left = 0;
   bit steady = 1'b0;

   periodic_waveform_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_time_tick    (req_time_tick),
      .rsp_valid        (rsp_valid),
      .rsp_sample       (rsp_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // quarter-wave sine in q30, truncated odd series evaluated in horner form
   initial begin : fill_quarter_wave
      longint unsigned x, x2, term, sub, s;
      int k, dd;
      for (k = 0; k <= 1024; k++) begin
         x = (HALF_PI_FIXED * longint'(k)) >> 10;
         x2 = (x * x) >> 30;
         term = ONE_Q30;
         for (dd = 12; dd >= 2; dd = dd - 2) begin
            sub = ((x2 * term) >> 30) / longint'(dd * (dd + 1));
            term = (sub >= ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
         end
         s = (x * term) >> 30;
         quarter_wave[k] = (s > ONE_Q30) ? ONE_Q30 : s;
      end
   end

   function automatic logic [SAMPLE_W-1:0] waveform_sample(logic [31:0] tick);
      logic [31:0] phase, q, d;
      int unsigned k;
      longint a, v, mag, t;
      phase = tick * cfg_step + cfg_offset;
      a = longint'(cfg_amp);
      case (cfg_wave)
         WAVE_SINE: begin
            // odd quadrants read the table mirrored, the upper half-turn is negated
            k = phase[30] ? 1024 - phase[29:20] : phase[29:20];
            mag = (a * longint'(quarter_wave[k]) + 64'sd536870912) >>> 30;
            v = phase[31] ? -mag : mag;
         end
         WAVE_TRIANGLE: begin
            q = phase + 32'hC000_0000;
            d = (q >= 32'h8000_0000) ? q - 32'h8000_0000 : 32'h8000_0000 - q;
            t = 4 * longint'(d) - TURN;
            v = (a * t + HALF_TURN) >>> 32;
         end
         WAVE_SQUARE: begin
            v = (phase != 0 && phase < 32'h8000_0000) ? a : -a;
         end
         default: begin
            v = (2 * a * longint'(signed'(phase)) + HALF_TURN) >>> 32;
         end
      endcase
      if (v > SAMPLE_MAX) begin
         v = SAMPLE_MAX;
      end
      if (v < SAMPLE_MIN) begin
         v = SAMPLE_MIN;
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic void note_error(string text);
      if (error_count < 10) begin
         $display("%s", text);
      end
      error_count++;
   endfunction

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         CSR_WAVEFORM_SELECT: cfg_wave = wave_type'(value[1:0]);
         CSR_PHASE_STEP: cfg_step = value;
         CSR_PHASE_OFFSET: cfg_offset = value;
         default: cfg_amp = value[AMP_W-1:0];
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic load_settings(logic [31:0] wave_word, logic [31:0] step_word,
                                logic [31:0] offset_word, logic [31:0] amp_word);
      write_register(CSR_WAVEFORM_SELECT, wave_word);
      write_register(CSR_PHASE_STEP, step_word);
      write_register(CSR_PHASE_OFFSET, offset_word);
      write_register(CSR_AMPLITUDE, amp_word);
   endtask

   task automatic wait_idle();
      while (pending_ticks.size() != 0 || start || expected_samples.size() != 0) begin
         @(negedge clock);
      end
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // driver: one transaction per tick, random gaps with occasional gap-free stretches
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_samples.push_back(waveform_sample(req_time_tick));
         end
         if (!(start && busy)) begin
            if ($urandom_range(0, 31) == 0) begin
               steady <= !steady;
            end
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               req_time_tick <= pending_ticks.pop_front();
               start <= 1'b1;
               gap_left <= steady ? 0 : $urandom_range(0, 7);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_samples
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_samples.size() == 0) begin
            note_error($sformatf("unexpected sample %0d", $signed(rsp_sample)));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want) begin
               note_error($sformatf("sample mismatch: expected %0d, got %0d",
                                    $signed(want), $signed(rsp_sample)));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int wave_num, phase_num, item_num, item_total;
      logic [31:0] step_word, offset_word, amp_word, run_tick, tick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // unit step from phase zero: quarter-turn corners, both square zero crossings
      // and the last tick before half and full turn; high garbage bits are masked
      for (wave_num = 0; wave_num < 4; wave_num++) begin
         load_settings(32'hFFFF_FFFC | 32'(wave_num), 32'd1, 32'd0, 32'hFFFF_FFFF);
         @(negedge clock);
         pending_ticks.push_back(32'h0000_0000);
         pending_ticks.push_back(32'h4000_0000);
         pending_ticks.push_back(32'h8000_0000);
         pending_ticks.push_back(32'hC000_0000);
         pending_ticks.push_back(32'h7FFF_FFFF);
         pending_ticks.push_back(32'hFFFF_FFFF);
         wait_idle();
      end

      for (phase_num = 0; phase_num < RANDOM_PHASES; phase_num++) begin
         case ($urandom_range(0, 5))
            0: step_word = 32'd0;
            1: step_word = 32'd1;
            2: step_word = 32'hFFFF_FFFF;
            3: step_word = 32'd1 << $urandom_range(0, 31);
            4: step_word = $urandom_range(1, 1 << 20);
            default: step_word = $urandom();
         endcase
         case ($urandom_range(0, 3))
            0: offset_word = 32'd0;
            1: offset_word = 32'hFFFF_FFFF;
            2: offset_word = {2'($urandom_range(0, 3)), 30'd0};
            default: offset_word = $urandom();
         endcase
         case ($urandom_range(0, 4))
            0: amp_word = 32'd0;
            1: amp_word = 32'd1;
            2: amp_word = 32'h7FFF;
            3: amp_word = $urandom_range(0, 32767);
            default: amp_word = $urandom();
         endcase
         load_settings(($urandom() & 32'hFFFF_FFFC) | 32'(phase_num % 4), step_word,
                       offset_word, amp_word);
         @(negedge clock);
         run_tick = $urandom();
         item_total = $urandom_range(30, 52);
         // mostly consecutive ticks so the waveform is swept, the rest scattered
         for (item_num = 0; item_num < item_total; item_num++) begin
            case ($urandom_range(0, 19))
               0: tick = 32'd0;
               1: tick = 32'hFFFF_FFFF;
               2: tick = 32'd1 << $urandom_range(0, 31);
               3, 4, 5, 6, 7: tick = $urandom();
               default: begin
                  tick = run_tick;
                  run_tick = run_tick + 1;
               end
            endcase
            pending_ticks.push_back(tick);
         end
         wait_idle();
      end

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
